/* rtl/nbg_pkg.sv */
// Shared types and constants for the n-body gravity step engine.
package nbg_pkg;

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP       = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_INTERVAL = 1'd1;

    localparam logic [15:0] TIME_STEP_RESET       = 16'd655;
    localparam logic [15:0] OUTPUT_INTERVAL_RESET = 16'd100;

    // Acceleration range, signed Q32.16
    localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

    // Root / divide unit step counts and first root bit
    localparam int          RU_DIV_STEPS  = 64;
    localparam int          RU_SQRT_STEPS = 32;
    localparam logic [63:0] RU_SQRT_BIT0  = 64'h4000_0000_0000_0000;

    typedef logic [3:0] t_body_idx;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] body_pos_x;
        logic signed [31:0] body_pos_y;
        logic signed [31:0] body_vel_x;
        logic signed [31:0] body_vel_y;
        logic [31:0]        body_mass;
    } t_in_word;

    typedef struct packed {
        t_body_idx          body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               coincident_seen;
        logic               last;
    } t_out_word;

    typedef enum logic {
        RU_DIV  = 1'b0,
        RU_SQRT = 1'b1
    } t_ru_mode;

    typedef struct packed {
        logic        start;
        t_ru_mode    mode;
        logic [63:0] num;
        logic [63:0] den;
    } t_ru_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_ru_rsp;

endpackage

/* rtl/nbg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/nbg_root_div.sv */
// Shared iterative unit: 64-bit restoring divide or 64-bit integer square root.
module nbg_root_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nbg_pkg::t_ru_req i_req,
    output nbg_pkg::t_ru_rsp o_rsp
);
    import nbg_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_ru_mode    r_mode;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;   // partial remainder
    logic [63:0] r_q;     // quotient (divide) or root (sqrt)
    logic [63:0] r_den;   // divisor (divide) or current root bit (sqrt)

    logic [64:0] w_lhs;
    logic [64:0] w_trial;
    logic [65:0] w_diff;
    logic        w_ge;

    // one shared compare/subtract per step
    always_comb begin
        if (r_mode == RU_SQRT) begin
            w_lhs   = {1'b0, r_rem};
            w_trial = {1'b0, r_q} + {1'b0, r_den};
        end else begin
            w_lhs   = {r_rem, r_q[63]};
            w_trial = {1'b0, r_den};
        end
        w_diff = {1'b0, w_lhs} - {1'b0, w_trial};
        w_ge   = !w_diff[65];
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= RU_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_cnt  <= (i_req.mode == RU_SQRT) ? 6'(RU_SQRT_STEPS - 1)
                                                  : 6'(RU_DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            if (i_req.mode == RU_SQRT) begin
                r_rem <= i_req.num;
                r_q   <= '0;
                r_den <= RU_SQRT_BIT0;
            end else begin
                r_rem <= '0;
                r_q   <= i_req.num;
                r_den <= i_req.den;
            end
        end else if (r_busy) begin
            if (r_mode == RU_SQRT) begin
                if (w_ge) begin
                    r_rem <= w_diff[63:0];
                    r_q   <= (r_q >> 1) + r_den;
                end else begin
                    r_q <= r_q >> 1;
                end
                r_den <= r_den >> 2;
            end else begin
                r_rem <= w_ge ? w_diff[63:0] : w_lhs[63:0];
                r_q   <= {r_q[62:0], w_ge};
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;
endmodule

/* rtl/nbody_gravity_step.sv */
// A step visits each ordered pair of bodies, N*(N-1) pairs, then updates the velocity and
// position of each body and counts the step. A coincident pair skips the root/divide work.
// Every other pair uses the shared root/divide unit: a 32-step root and two 64-step
// quotients per axis. An emission sends the body positions out one word at a time.
// Synchronous active-low reset clears control, count, flags, step counter; loads dt 655,
// interval 100.
module nbody_gravity_step #(
    parameter int MAX_BODIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nbg_pkg::t_in_word                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nbg_pkg::t_out_word                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [nbg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [15:0]                       i_cfg_wdata
);
    import nbg_pkg::*;

    localparam int IW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    typedef enum logic [25:0] {
        ST_IDLE   = 26'b1,
        ST_PI_RD  = 26'b1 << 1,
        ST_PI_LD  = 26'b1 << 2,
        ST_PJ_RD  = 26'b1 << 3,
        ST_PJ_LD  = 26'b1 << 4,
        ST_SQX    = 26'b1 << 5,
        ST_SQY    = 26'b1 << 6,
        ST_R2     = 26'b1 << 7,
        ST_ROOT   = 26'b1 << 8,
        ST_UDIV   = 26'b1 << 9,
        ST_KU     = 26'b1 << 10,
        ST_MAG    = 26'b1 << 11,
        ST_ACC    = 26'b1 << 12,
        ST_ACC_WR = 26'b1 << 13,
        ST_UP_RD  = 26'b1 << 14,
        ST_UP_LD  = 26'b1 << 15,
        ST_AV_LO  = 26'b1 << 16,
        ST_AV_HI  = 26'b1 << 17,
        ST_V_ADD  = 26'b1 << 18,
        ST_PV_MUL = 26'b1 << 19,
        ST_P_ADD  = 26'b1 << 20,
        ST_UP_WR  = 26'b1 << 21,
        ST_COUNT  = 26'b1 << 22,
        ST_EM_RD  = 26'b1 << 23,
        ST_EM_LD  = 26'b1 << 24,
        ST_EM_OUT = 26'b1 << 25
    } t_state;

    // clamp a 49-bit signed sum to the signed 32-bit range
    function automatic logic [31:0] f_sat32(input logic [48:0] s);
        logic same;
        same = (&s[48:31]) || !(|s[48:31]);
        if (same) begin
            return s[31:0];
        end
        return s[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic          r_axis;
    logic [15:0]   r_stepc;
    logic [15:0]   r_dt;
    logic [15:0]   r_oint;
    logic [MAX_BODIES-1:0] r_flags;
    logic          r_out_valid;
    t_out_word     r_out;

    // datapath registers
    logic [31:0]   r_pix, r_piy;
    logic [32:0]   r_d [2];
    logic [31:0]   r_k;
    logic [63:0]   r_sq;
    logic [63:0]   r_r2;
    logic [31:0]   r_r;
    logic [63:0]   r_mag;
    logic [47:0]   r_acc [2];
    logic [47:0]   r_a [2];
    logic [31:0]   r_v [2];
    logic [31:0]   r_p [2];
    logic [63:0]   r_lo;
    logic signed [65:0] r_prod;

    logic signed [32:0] w_mul_a, w_mul_b;
    t_ru_req       w_ru_req;
    t_ru_rsp       w_ru_rsp;

    logic [63:0]   w_pos_rd, w_vel_rd;
    logic [31:0]   w_mass_rd;
    logic [95:0]   w_acc_rd;
    logic [IW-1:0] w_raddr;

    logic          w_in_acc, w_room, w_load;
    logic          w_j_end, w_j_self, w_i_last;
    logic [31:0]   w_abs [2];
    logic [64:0]   w_r2_sum;
    logic [63:0]   w_r2;
    logic [47:0]   w_mag_c, w_term, w_acc_sat;
    logic [48:0]   w_acc_sum;
    logic [63:0]   w_full;
    logic [47:0]   w_sh;
    logic [48:0]   w_v_sum, w_p_sum;
    logic [31:0]   w_psh;
    logic [15:0]   w_step_next;
    logic          w_emit;

    // handshake and loop conditions
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_room     = (r_count < CW'(MAX_BODIES));
    assign w_load     = w_in_acc && (i_in_data.cmd == CMD_LOAD) && w_room;
    assign w_j_end    = (r_j == r_count);
    assign w_j_self   = (r_j == CW'(r_i));
    assign w_i_last   = ((CW'(r_i) + CW'(1)) == r_count);
    assign w_raddr    = (r_state == ST_PJ_RD) ? r_j[IW-1:0] : r_i;
    assign w_step_next = r_stepc + 16'd1;
    assign w_emit     = (w_step_next >= r_oint);

    // pair arithmetic
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_abs[a] = r_d[a][32] ? 32'(-r_d[a]) : r_d[a][31:0];
        end
        w_r2_sum = {1'b0, r_sq} + {1'b0, r_prod[63:0]};
        w_r2     = w_r2_sum[64] ? '1 : w_r2_sum[63:0];
        w_mag_c  = (|r_mag[63:47]) ? ACC_MAX : r_mag[47:0];
        w_term   = r_d[r_axis][32] ? -w_mag_c : w_mag_c;
        w_acc_sum = {r_acc[r_axis][47], r_acc[r_axis]} + {w_term[47], w_term};
        if (w_acc_sum[48] != w_acc_sum[47]) begin
            w_acc_sat = w_acc_sum[48] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_sat = w_acc_sum[47:0];
        end
    end

    // update arithmetic: v += a*dt, p += v*dt, floor shift by 16
    always_comb begin
        w_full  = {r_prod[31:0], 32'b0} + r_lo;
        w_sh    = w_full[63:16];
        w_v_sum = {{17{r_v[r_axis][31]}}, r_v[r_axis]} + {w_sh[47], w_sh};
        w_psh   = r_prod[47:16];
        w_p_sum = {{17{r_p[r_axis][31]}}, r_p[r_axis]} + {{17{w_psh[31]}}, w_psh};
    end

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_SQX: begin
                w_mul_a = {1'b0, w_abs[0]};
                w_mul_b = {1'b0, w_abs[0]};
            end
            ST_SQY: begin
                w_mul_a = {1'b0, w_abs[1]};
                w_mul_b = {1'b0, w_abs[1]};
            end
            ST_UDIV: begin
                w_mul_a = {1'b0, r_k};
                w_mul_b = {1'b0, w_ru_rsp.result[31:0]};
            end
            ST_AV_LO: begin
                w_mul_a = {1'b0, r_a[r_axis][31:0]};
                w_mul_b = {17'b0, r_dt};
            end
            ST_AV_HI: begin
                w_mul_a = {{17{r_a[r_axis][47]}}, r_a[r_axis][47:32]};
                w_mul_b = {17'b0, r_dt};
            end
            ST_PV_MUL: begin
                w_mul_a = {r_v[r_axis][31], r_v[r_axis]};
                w_mul_b = {17'b0, r_dt};
            end
            default: ;
        endcase
    end

    // root/divide unit requests
    always_comb begin
        w_ru_req = '0;
        case (r_state)
            ST_R2: begin
                w_ru_req.start = (w_r2 != '0);
                w_ru_req.mode  = RU_SQRT;
                w_ru_req.num   = w_r2;
            end
            ST_ROOT: begin
                w_ru_req.start = w_ru_rsp.done;
                w_ru_req.mode  = RU_DIV;
                w_ru_req.num   = {1'b0, w_abs[0], 31'b0};
                w_ru_req.den   = {32'b0, w_ru_rsp.result[31:0]};
            end
            ST_KU: begin
                w_ru_req.start = 1'b1;
                w_ru_req.mode  = RU_DIV;
                w_ru_req.num   = {r_prod[62:0], 1'b0};
                w_ru_req.den   = r_r2;
            end
            ST_ACC: begin
                w_ru_req.start = !r_axis;
                w_ru_req.mode  = RU_DIV;
                w_ru_req.num   = {1'b0, w_abs[1], 31'b0};
                w_ru_req.den   = {32'b0, r_r};
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_data.cmd == CMD_STEP)) begin
                    n_state = (r_count == '0) ? ST_COUNT : ST_PI_RD;
                end
            end
            ST_PI_RD:  n_state = ST_PI_LD;
            ST_PI_LD:  n_state = ST_PJ_RD;
            ST_PJ_RD: begin
                if (w_j_end) begin
                    n_state = ST_ACC_WR;
                end else if (!w_j_self) begin
                    n_state = ST_PJ_LD;
                end
            end
            ST_PJ_LD:  n_state = ST_SQX;
            ST_SQX:    n_state = ST_SQY;
            ST_SQY:    n_state = ST_R2;
            ST_R2:     n_state = (w_r2 == '0) ? ST_PJ_RD : ST_ROOT;
            ST_ROOT:   if (w_ru_rsp.done) n_state = ST_UDIV;
            ST_UDIV:   if (w_ru_rsp.done) n_state = ST_KU;
            ST_KU:     n_state = ST_MAG;
            ST_MAG:    if (w_ru_rsp.done) n_state = ST_ACC;
            ST_ACC:    n_state = r_axis ? ST_PJ_RD : ST_UDIV;
            ST_ACC_WR: n_state = w_i_last ? ST_UP_RD : ST_PI_RD;
            ST_UP_RD:  n_state = ST_UP_LD;
            ST_UP_LD:  n_state = ST_AV_LO;
            ST_AV_LO:  n_state = ST_AV_HI;
            ST_AV_HI:  n_state = ST_V_ADD;
            ST_V_ADD:  n_state = r_axis ? ST_PV_MUL : ST_AV_LO;
            ST_PV_MUL: n_state = ST_P_ADD;
            ST_P_ADD:  n_state = r_axis ? ST_UP_WR : ST_PV_MUL;
            ST_UP_WR:  n_state = w_i_last ? ST_COUNT : ST_UP_RD;
            ST_COUNT:  n_state = (w_emit && (r_count != '0)) ? ST_EM_RD : ST_IDLE;
            ST_EM_RD:  n_state = ST_EM_LD;
            ST_EM_LD:  n_state = ST_EM_OUT;
            ST_EM_OUT: begin
                if (!i_out_stall) begin
                    n_state = w_i_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_axis      <= 1'b0;
            r_stepc     <= '0;
            r_dt        <= TIME_STEP_RESET;
            r_oint      <= OUTPUT_INTERVAL_RESET;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TIME_STEP:       r_dt   <= i_cfg_wdata;
                    REG_OUTPUT_INTERVAL: r_oint <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in_data.cmd)
                            CMD_LOAD: begin
                                if (w_room) begin
                                    r_flags[r_count[IW-1:0]] <= 1'b0;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_flags <= '0;
                            end
                            CMD_STEP: r_i <= '0;
                            default: ;
                        endcase
                    end
                end
                ST_PI_LD: r_j <= '0;
                ST_PJ_RD: begin
                    if (!w_j_end && w_j_self) begin
                        r_j <= r_j + CW'(1);
                    end
                end
                ST_R2: begin
                    if (w_r2 == '0) begin
                        r_flags[r_i] <= 1'b1;
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_axis <= 1'b0;
                    end
                end
                ST_ACC: begin
                    if (r_axis) begin
                        r_j <= r_j + CW'(1);
                    end
                    r_axis <= !r_axis;
                end
                ST_ACC_WR: r_i <= w_i_last ? '0 : r_i + IW'(1);
                ST_UP_LD:  r_axis <= 1'b0;
                ST_V_ADD:  r_axis <= !r_axis;
                ST_P_ADD:  r_axis <= !r_axis;
                ST_UP_WR: begin
                    if (!w_i_last) begin
                        r_i <= r_i + IW'(1);
                    end
                end
                ST_COUNT: begin
                    if (w_emit) begin
                        r_stepc <= '0;
                        r_i     <= '0;
                    end else begin
                        r_stepc <= w_step_next;
                    end
                end
                ST_EM_LD: begin
                    r_flags[r_i] <= 1'b0;
                    r_out_valid  <= 1'b1;
                end
                ST_EM_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (!w_i_last) begin
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            ST_PI_LD: begin
                r_pix    <= w_pos_rd[31:0];
                r_piy    <= w_pos_rd[63:32];
                r_acc[0] <= '0;
                r_acc[1] <= '0;
            end
            ST_PJ_LD: begin
                r_d[0] <= {w_pos_rd[31], w_pos_rd[31:0]} - {r_pix[31], r_pix};
                r_d[1] <= {w_pos_rd[63], w_pos_rd[63:32]} - {r_piy[31], r_piy};
                r_k    <= w_mass_rd;
            end
            ST_SQY:  r_sq <= r_prod[63:0];
            ST_R2:   r_r2 <= w_r2;
            ST_ROOT: if (w_ru_rsp.done) r_r <= w_ru_rsp.result[31:0];
            ST_MAG:  if (w_ru_rsp.done) r_mag <= w_ru_rsp.result;
            ST_ACC:  r_acc[r_axis] <= w_acc_sat;
            ST_UP_LD: begin
                r_a[0] <= w_acc_rd[47:0];
                r_a[1] <= w_acc_rd[95:48];
                r_v[0] <= w_vel_rd[31:0];
                r_v[1] <= w_vel_rd[63:32];
                r_p[0] <= w_pos_rd[31:0];
                r_p[1] <= w_pos_rd[63:32];
            end
            ST_AV_HI: r_lo <= r_prod[63:0];
            ST_V_ADD: r_v[r_axis] <= f_sat32(w_v_sum);
            ST_P_ADD: r_p[r_axis] <= f_sat32(w_p_sum);
            ST_EM_LD: begin
                r_out.body_index      <= t_body_idx'(r_i);
                r_out.pos_x           <= w_pos_rd[31:0];
                r_out.pos_y           <= w_pos_rd[63:32];
                r_out.coincident_seen <= r_flags[r_i];
                r_out.last            <= w_i_last;
            end
            default: ;
        endcase
    end

    // body tables
    nbg_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_load || (r_state == ST_UP_WR)),
        .i_waddr (w_load ? r_count[IW-1:0] : r_i),
        .i_wdata (w_load ? {i_in_data.body_pos_y, i_in_data.body_pos_x} : {r_p[1], r_p[0]}),
        .i_raddr (w_raddr),
        .o_rdata (w_pos_rd)
    );

    nbg_ram #(.WIDTH(64), .DEPTH(MAX_BODIES)) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (w_load || (r_state == ST_UP_WR)),
        .i_waddr (w_load ? r_count[IW-1:0] : r_i),
        .i_wdata (w_load ? {i_in_data.body_vel_y, i_in_data.body_vel_x} : {r_v[1], r_v[0]}),
        .i_raddr (w_raddr),
        .o_rdata (w_vel_rd)
    );

    nbg_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_mass_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_in_data.body_mass),
        .i_raddr (w_raddr),
        .o_rdata (w_mass_rd)
    );

    nbg_ram #(.WIDTH(96), .DEPTH(MAX_BODIES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_ACC_WR),
        .i_waddr (r_i),
        .i_wdata ({r_acc[1], r_acc[0]}),
        .i_raddr (w_raddr),
        .o_rdata (w_acc_rd)
    );

    // shared root / divide unit
    nbg_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ru_req),
        .o_rsp   (w_ru_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EM_OUT))
        else $error("output word valid outside emission");

    a_ru_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ru_req.start |-> !w_ru_rsp.busy)
        else $error("root/divide unit started while busy");

    a_ru_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ru_rsp.done |-> (r_state == ST_ROOT || r_state == ST_UDIV || r_state == ST_MAG))
        else $error("root/divide result arrived with no waiting state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PJ_LD) |-> ((r_count <= CW'(MAX_BODIES)) && (CW'(r_i) < r_count)))
        else $error("body index out of table range");

endmodule
